// ----- design/slr_pkg.sv -----
// Shared constants, register codes and the configuration type for the line rasteriser.
package slr_pkg;

    // Default sizes handed to the top level parameters.
    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS_DEF = 24;
    // Colour bits that survive into the result.
    localparam int COLOR_KEEP_BITS = 24;

    // Configuration field widths.
    localparam int STYLE_BITS     = 2;
    localparam int THICK_BITS     = 6;
    localparam int DASH_BITS      = 8;
    localparam int OFFSET_BITS    = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;

    // Line styles; the unused code behaves as solid.
    localparam logic [STYLE_BITS-1:0] STYLE_SOLID  = 2'd0;
    localparam logic [STYLE_BITS-1:0] STYLE_THICK  = 2'd1;
    localparam logic [STYLE_BITS-1:0] STYLE_DASHED = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_STYLE  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THICKNESS   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DASH_LENGTH = 2'd2;

    // Input word operations.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Register values after reset.
    localparam logic [STYLE_BITS-1:0] RESET_LINE_STYLE  = STYLE_SOLID;
    localparam logic [THICK_BITS-1:0] RESET_THICKNESS   = 6'd1;
    localparam logic [DASH_BITS-1:0]  RESET_DASH_LENGTH = 8'd4;

    typedef struct packed {
        logic [STYLE_BITS-1:0] line_style;
        logic [THICK_BITS-1:0] thickness;
        logic [DASH_BITS-1:0]  dash_length;
    } cfg_t;

endpackage

// ----- design/slr_in_reg.sv -----
// Input register stage holding one accepted word until the core takes it.
module slr_in_reg #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  op,
    input  logic [COORD_BITS-2:0] x_start,
    input  logic [COORD_BITS-2:0] y_start,
    input  logic [COORD_BITS-2:0] x_end,
    input  logic [COORD_BITS-2:0] y_end,
    input  logic [COLOR_BITS-1:0] color,
    input  logic                  take,
    output logic                  item_valid,
    output logic                  item_op,
    output logic [COORD_BITS-2:0] item_x_start,
    output logic [COORD_BITS-2:0] item_y_start,
    output logic [COORD_BITS-2:0] item_x_end,
    output logic [COORD_BITS-2:0] item_y_end,
    output logic [COLOR_BITS-1:0] item_color
);
    logic                  valid_reg;
    logic                  op_reg;
    logic [COORD_BITS-2:0] x_start_reg;
    logic [COORD_BITS-2:0] y_start_reg;
    logic [COORD_BITS-2:0] x_end_reg;
    logic [COORD_BITS-2:0] y_end_reg;
    logic [COLOR_BITS-1:0] color_reg;

    // The stage refills in the same cycle as the core empties it.
    assign s_tready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg      <= op;
            x_start_reg <= x_start;
            y_start_reg <= y_start;
            x_end_reg   <= x_end;
            y_end_reg   <= y_end;
            color_reg   <= color;
        end
    end

    assign item_valid   = valid_reg;
    assign item_op      = op_reg;
    assign item_x_start = x_start_reg;
    assign item_y_start = y_start_reg;
    assign item_x_end   = x_end_reg;
    assign item_y_end   = y_end_reg;
    assign item_color   = color_reg;

endmodule

// ----- design/slr_core.sv -----
// Line state and the Bresenham step with thick and dashed styling.
module slr_core #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_op,
    input  logic [COORD_BITS-2:0] item_x_start,
    input  logic [COORD_BITS-2:0] item_y_start,
    input  logic [COORD_BITS-2:0] item_x_end,
    input  logic [COORD_BITS-2:0] item_y_end,
    input  logic [COLOR_BITS-1:0] item_color,
    input  slr_pkg::cfg_t         cfg,
    input  logic                  space,
    output logic                  take,
    output logic                  res_load,
    output logic [COORD_BITS:0]   res_x,
    output logic [COORD_BITS:0]   res_y,
    output logic [COLOR_BITS-1:0] res_color,
    output logic                  res_draw,
    output logic                  res_last
);
    import slr_pkg::*;

    localparam int PT_W   = COORD_BITS - 1;
    localparam int PIX_W  = COORD_BITS + 1;
    localparam int ERR_W  = COORD_BITS + 2;
    localparam int E2_W   = COORD_BITS + 3;
    localparam int KEEP_W = (COLOR_BITS < COLOR_KEEP_BITS) ? COLOR_BITS : COLOR_KEEP_BITS;
    localparam logic [COLOR_BITS-1:0] COL_MASK =
        COLOR_BITS'((64'd1 << KEEP_W) - 64'd1);

    logic                          busy_reg;
    logic [PT_W-1:0]               cur_x_reg;
    logic [PT_W-1:0]               cur_y_reg;
    logic [PT_W-1:0]               end_x_reg;
    logic [PT_W-1:0]               end_y_reg;
    logic [PT_W-1:0]               start_x_reg;
    logic [PT_W-1:0]               start_y_reg;
    logic signed [ERR_W-1:0]       err_reg;
    logic [PT_W-1:0]               dx_reg;
    logic [PT_W-1:0]               dy_reg;
    logic                          sign_x_reg;
    logic                          sign_y_reg;
    logic signed [OFFSET_BITS-1:0] offset_reg;
    logic                          off_y_reg;
    logic [DASH_BITS-1:0]          dash_cnt_reg;
    logic                          dash_on_reg;
    logic [COLOR_BITS-1:0]         color_reg;

    logic [THICK_BITS-2:0]         half;
    logic signed [OFFSET_BITS-1:0] half_s;
    logic [PT_W-1:0]               dx_new;
    logic [PT_W-1:0]               dy_new;
    logic                          is_step;
    logic                          at_end;
    logic                          more_pass;
    logic                          dashed;
    logic [DASH_BITS-1:0]          dash_inc;
    logic                          dash_hit;
    logic signed [E2_W-1:0]        e2;
    logic                          step_x;
    logic                          step_y;
    logic signed [ERR_W-1:0]       err_after;
    logic [PIX_W-1:0]              off_ext;

    assign half   = cfg.thickness[THICK_BITS-1:1];
    assign half_s = $signed(OFFSET_BITS'(half));

    assign dx_new = (item_x_end > item_x_start) ? item_x_end - item_x_start
                                                : item_x_start - item_x_end;
    assign dy_new = (item_y_end > item_y_start) ? item_y_end - item_y_start
                                                : item_y_start - item_y_end;

    assign is_step   = (item_op == OP_STEP);
    assign at_end    = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
    assign more_pass = (cfg.line_style == STYLE_THICK) && (offset_reg < half_s);
    assign dashed    = (cfg.line_style == STYLE_DASHED);

    // The dash counter wraps and toggles the pen when it meets the dash length.
    assign dash_inc = dash_cnt_reg + DASH_BITS'(1);
    assign dash_hit = (cfg.dash_length != '0) && (dash_inc == cfg.dash_length);

    // Bresenham decision on twice the error term.
    assign e2        = $signed({err_reg, 1'b0});
    assign step_x    = e2 >= -$signed(E2_W'(dy_reg));
    assign step_y    = e2 <= $signed(E2_W'(dx_reg));
    assign err_after = err_reg
                     - (step_x ? $signed(ERR_W'(dy_reg)) : $signed(ERR_W'(0)))
                     + (step_y ? $signed(ERR_W'(dx_reg)) : $signed(ERR_W'(0)));

    // A step word waits only when it would produce a result with nowhere to go.
    assign take     = item_valid && !(is_step && busy_reg && !space);
    assign res_load = take && is_step && busy_reg;

    assign off_ext   = PIX_W'(offset_reg);
    assign res_x     = PIX_W'(cur_x_reg) + (off_y_reg ? '0 : off_ext);
    assign res_y     = PIX_W'(cur_y_reg) + (off_y_reg ? off_ext : '0);
    assign res_color = color_reg;
    assign res_draw  = dashed ? dash_on_reg : 1'b1;
    assign res_last  = at_end && !more_pass;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            end_x_reg    <= '0;
            end_y_reg    <= '0;
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            err_reg      <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            sign_x_reg   <= 1'b0;
            sign_y_reg   <= 1'b0;
            offset_reg   <= '0;
            off_y_reg    <= 1'b0;
            dash_cnt_reg <= '0;
            dash_on_reg  <= 1'b1;
            color_reg    <= '0;
        end
        else if (take && !is_step)
        begin
            // A new line replaces whatever was in progress.
            busy_reg     <= 1'b1;
            start_x_reg  <= item_x_start;
            start_y_reg  <= item_y_start;
            cur_x_reg    <= item_x_start;
            cur_y_reg    <= item_y_start;
            end_x_reg    <= item_x_end;
            end_y_reg    <= item_y_end;
            dx_reg       <= dx_new;
            dy_reg       <= dy_new;
            err_reg      <= $signed(ERR_W'(dx_new)) - $signed(ERR_W'(dy_new));
            sign_x_reg   <= !(item_x_start < item_x_end);
            sign_y_reg   <= !(item_y_start < item_y_end);
            off_y_reg    <= dx_new > dy_new;
            offset_reg   <= (cfg.line_style == STYLE_THICK) ? -half_s : '0;
            color_reg    <= item_color & COL_MASK;
            dash_cnt_reg <= '0;
            dash_on_reg  <= 1'b1;
        end
        else if (res_load)
        begin
            if (dashed)
            begin
                dash_cnt_reg <= dash_hit ? '0 : dash_inc;
                if (dash_hit)
                begin
                    dash_on_reg <= !dash_on_reg;
                end
            end
            if (at_end)
            begin
                if (more_pass)
                begin
                    // Next thick pass restarts from the first endpoint.
                    offset_reg <= offset_reg + $signed(OFFSET_BITS'(1));
                    cur_x_reg  <= start_x_reg;
                    cur_y_reg  <= start_y_reg;
                    err_reg    <= $signed(ERR_W'(dx_reg)) - $signed(ERR_W'(dy_reg));
                end
                else
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                err_reg <= err_after;
                if (step_x)
                begin
                    cur_x_reg <= sign_x_reg ? cur_x_reg - PT_W'(1) : cur_x_reg + PT_W'(1);
                end
                if (step_y)
                begin
                    cur_y_reg <= sign_y_reg ? cur_y_reg - PT_W'(1) : cur_y_reg + PT_W'(1);
                end
            end
        end
    end

endmodule

// ----- design/slr_out_reg.sv -----
// Result register that holds one pixel word until the downstream side takes it.
module slr_out_reg #(
    parameter int COORD_BITS = 12,
    parameter int COLOR_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [COORD_BITS:0]   res_x,
    input  logic [COORD_BITS:0]   res_y,
    input  logic [COLOR_BITS-1:0] res_color,
    input  logic                  res_draw,
    input  logic                  res_last,
    output logic                  space,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [COORD_BITS:0]   pixel_x,
    output logic [COORD_BITS:0]   pixel_y,
    output logic [COLOR_BITS-1:0] pixel_color,
    output logic                  draw,
    output logic                  last
);
    logic                  valid_reg;
    logic [COORD_BITS:0]   x_reg;
    logic [COORD_BITS:0]   y_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  draw_reg;
    logic                  last_reg;

    assign space = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg     <= res_x;
            y_reg     <= res_y;
            color_reg <= res_color;
            draw_reg  <= res_draw;
            last_reg  <= res_last;
        end
    end

    assign m_tvalid    = valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign pixel_color = color_reg;
    assign draw        = draw_reg;
    assign last        = last_reg;

endmodule

// ----- design/styled_line_rasterizer.sv -----
// Path: a step word passes the input register and then the result register as its pixel word; start
// words give none. Throughput: one word per cycle in both directions while m_tready stays high, since
// each Bresenham step is one add and compare between the input register and the result register.
// Reset: rst_n clears the line state (no line in progress) and sets style solid, thickness one and
// dash length four; both word stages come out of reset empty.
module styled_line_rasterizer #(
    parameter int COORD_BITS = slr_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = slr_pkg::COLOR_BITS_DEF,
    localparam int IN_DATA_W  = ((4 * (COORD_BITS - 1) + COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * (COORD_BITS + 1) + COLOR_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input words.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_start, y_start, x_end, y_end, color from bit 0 upwards, zero padded.
    input  logic [IN_DATA_W-1:0]                s_tdata,
    // op: start a new line or step to the next pixel.
    input  logic                                s_tuser,
    // Pixel words.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_x, pixel_y, pixel_color from bit 0 upwards, zero padded.
    output logic [OUT_DATA_W-1:0]               m_tdata,
    // draw: pixel is written, clear in a dash gap.
    output logic                                m_tuser,
    // last: final pixel of the whole line, across every thick pass.
    output logic                                m_tlast,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [slr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import slr_pkg::*;

    localparam int PT_W  = COORD_BITS - 1;
    localparam int PIX_W = COORD_BITS + 1;

    // Configuration registers. They are read live by every step, so a change between steps
    // takes effect on the next pixel; the thick offset chosen at start stays applied.
    cfg_t cfg_reg;

    logic                  item_valid;
    logic                  item_op;
    logic [PT_W-1:0]       item_x_start;
    logic [PT_W-1:0]       item_y_start;
    logic [PT_W-1:0]       item_x_end;
    logic [PT_W-1:0]       item_y_end;
    logic [COLOR_BITS-1:0] item_color;
    logic                  take;
    logic                  space;
    logic                  res_load;
    logic [PIX_W-1:0]      res_x;
    logic [PIX_W-1:0]      res_y;
    logic [COLOR_BITS-1:0] res_color;
    logic                  res_draw;
    logic                  res_last;
    logic [PIX_W-1:0]      pixel_x;
    logic [PIX_W-1:0]      pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;

    // Configuration is always accepted; writes to the unused index are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_style  <= RESET_LINE_STYLE;
            cfg_reg.thickness   <= RESET_THICKNESS;
            cfg_reg.dash_length <= RESET_DASH_LENGTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LINE_STYLE:  cfg_reg.line_style  <= cfg_data[STYLE_BITS-1:0];
                REG_THICKNESS:   cfg_reg.thickness   <= cfg_data[THICK_BITS-1:0];
                REG_DASH_LENGTH: cfg_reg.dash_length <= cfg_data[DASH_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register: a word is held here while the core works on it, and the next
    // word is taken in the same cycle that this one moves on.
    slr_in_reg #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_in_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .op           (s_tuser),
        .x_start      (s_tdata[PT_W-1:0]),
        .y_start      (s_tdata[2*PT_W-1:PT_W]),
        .x_end        (s_tdata[3*PT_W-1:2*PT_W]),
        .y_end        (s_tdata[4*PT_W-1:3*PT_W]),
        .color        (s_tdata[4*PT_W+COLOR_BITS-1:4*PT_W]),
        .take         (take),
        .item_valid   (item_valid),
        .item_op      (item_op),
        .item_x_start (item_x_start),
        .item_y_start (item_y_start),
        .item_x_end   (item_x_end),
        .item_y_end   (item_y_end),
        .item_color   (item_color)
    );

    // Core: holds the line state and advances it by one pixel per step word. A start word
    // loads a new line, dropping any line in progress; a step word with no line is discarded.
    slr_core #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_op      (item_op),
        .item_x_start (item_x_start),
        .item_y_start (item_y_start),
        .item_x_end   (item_x_end),
        .item_y_end   (item_y_end),
        .item_color   (item_color),
        .cfg          (cfg_reg),
        .space        (space),
        .take         (take),
        .res_load     (res_load),
        .res_x        (res_x),
        .res_y        (res_y),
        .res_color    (res_color),
        .res_draw     (res_draw),
        .res_last     (res_last)
    );

    // Result register: keeps the pixel word steady while the downstream side stalls, and is
    // reloaded in the same cycle that its word is taken.
    slr_out_reg #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (res_load),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_color   (res_color),
        .res_draw    (res_draw),
        .res_last    (res_last),
        .space       (space),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .draw        (m_tuser),
        .last        (m_tlast)
    );

    // Pack the pixel word with the padding bits held at zero.
    always_comb
    begin
        m_tdata = '0;
        m_tdata[PIX_W-1:0]                       = pixel_x;
        m_tdata[2*PIX_W-1:PIX_W]                 = pixel_y;
        m_tdata[2*PIX_W+COLOR_BITS-1:2*PIX_W]    = pixel_color;
    end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the styled line rasteriser: random stream traffic against a pixel predictor.
module tb;
    import slr_pkg::*;

    // Field widths as the block packs them.
    localparam int CW    = COORD_BITS_DEF - 1;
    localparam int PW    = COORD_BITS_DEF + 1;
    localparam int KW    = COLOR_KEEP_BITS;
    localparam int IN_W  = ((4 * CW + COLOR_BITS_DEF + 7) / 8) * 8;
    localparam int OUT_W = ((2 * PW + COLOR_BITS_DEF + 7) / 8) * 8;
    localparam int X_MAX = (1 << CW) - 1;
    // Bit positions of the pixel word fields.
    localparam int PX_LO = 0;
    localparam int PY_LO = PW;
    localparam int PC_LO = 2 * PW;
    // The spare style code, which the block treats as solid.
    localparam logic [STYLE_BITS-1:0] STYLE_SPARE = 2'd3;
    localparam logic signed [PW-1:0] UNIT = 1;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] x0;
        logic [CW-1:0] y0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
        logic [23:0]   colour;
    } line_word_t;

    typedef struct packed {
        logic [PW-1:0] x;
        logic [PW-1:0] y;
        logic [KW-1:0] colour;
        logic          draw;
        logic          last;
    } pixel_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_W-1:0]           s_tdata = '0;
    logic                      s_tuser = OP_START;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_W-1:0]          m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_LINE_STYLE;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    styled_line_rasterizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Words waiting to be sent, pixels waiting to arrive, and bookkeeping.
    line_word_t pending_words[$];
    pixel_t     expected_pixels[$];
    line_word_t tx_word;
    int         tx_wait = 0;
    int         rx_wait = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    int         words_queued = 0;
    int         words_taken = 0;
    int         mismatches = 0;
    int         open_steps = 0;

    // Register copies, updated as each configuration word is accepted.
    logic [STYLE_BITS-1:0] style_q = RESET_LINE_STYLE;
    logic [THICK_BITS-1:0] thick_q = RESET_THICKNESS;
    logic [DASH_BITS-1:0]  dash_q  = RESET_DASH_LENGTH;

    // Line engine state as the predictor sees it, at reset values.
    bit                       ln_busy = 1'b0;
    logic signed [PW-1:0]     ln_x = '0;
    logic signed [PW-1:0]     ln_y = '0;
    logic signed [PW-1:0]     ln_end_x = '0;
    logic signed [PW-1:0]     ln_end_y = '0;
    logic signed [PW-1:0]     ln_org_x = '0;
    logic signed [PW-1:0]     ln_org_y = '0;
    logic signed [14:0]       ln_err = '0;
    logic signed [CW:0]       ln_dx = '0;
    logic signed [CW:0]       ln_dy = '0;
    logic [1:0]               ln_dir = '0;
    logic signed [OFFSET_BITS-1:0] ln_offset = '0;
    bit                       ln_along_y = 1'b0;
    logic [DASH_BITS-1:0]     dash_count = '0;
    bit                       dash_on = 1'b1;
    logic [KW-1:0]            ln_colour = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the pixel, if any, that one accepted input word gives, and moves the engine on.
    function automatic void trace_pixel(input line_word_t w);
        logic signed [OFFSET_BITS-1:0] half;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [15:0] e2;
        logic at_end;
        logic more_pass;
        logic dot;
        pixel_t p;
        half = 7'(thick_q >> 1);
        if (w.op == OP_START)
        begin
            ln_org_x   = $signed({2'b00, w.x0});
            ln_org_y   = $signed({2'b00, w.y0});
            ln_end_x   = $signed({2'b00, w.x1});
            ln_end_y   = $signed({2'b00, w.y1});
            ln_dx      = $signed({1'b0, ((w.x1 > w.x0) ? w.x1 - w.x0 : w.x0 - w.x1)});
            ln_dy      = $signed({1'b0, ((w.y1 > w.y0) ? w.y1 - w.y0 : w.y0 - w.y1)});
            ln_dir     = {(w.y0 < w.y1) ? 1'b0 : 1'b1, (w.x0 < w.x1) ? 1'b0 : 1'b1};
            ln_along_y = ln_dx > ln_dy;
            ln_offset  = (style_q == STYLE_THICK) ? -half : 7'sd0;
            ln_colour  = w.colour;
            dash_count = '0;
            dash_on    = 1'b1;
            ln_busy    = 1'b1;
            ln_x       = ln_org_x;
            ln_y       = ln_org_y;
            ln_err     = 15'(ln_dx - ln_dy);
        end
        else if (ln_busy)
        begin
            px        = ln_along_y ? ln_x : ln_x + ln_offset;
            py        = ln_along_y ? ln_y + ln_offset : ln_y;
            at_end    = (ln_x == ln_end_x) && (ln_y == ln_end_y);
            more_pass = (style_q == STYLE_THICK) && (ln_offset < half);
            dot       = 1'b1;
            if (style_q == STYLE_DASHED)
            begin
                dot        = dash_on;
                dash_count = dash_count + 8'd1;
                if (dash_q != '0 && dash_count == dash_q)
                begin
                    dash_on    = !dash_on;
                    dash_count = '0;
                end
            end
            p.x      = px;
            p.y      = py;
            p.colour = ln_colour;
            p.draw   = dot;
            p.last   = at_end && !more_pass;
            expected_pixels.push_back(p);
            if (at_end)
            begin
                if (more_pass)
                begin
                    // Next thick pass: back to the first endpoint one offset further on.
                    ln_offset = ln_offset + 7'sd1;
                    ln_x      = ln_org_x;
                    ln_y      = ln_org_y;
                    ln_err    = 15'(ln_dx - ln_dy);
                end
                else
                    ln_busy = 1'b0;
            end
            else
            begin
                e2 = 16'(ln_err * 2);
                if (e2 >= -ln_dy)
                begin
                    ln_err = ln_err - ln_dy;
                    ln_x   = ln_dir[0] ? ln_x - UNIT : ln_x + UNIT;
                end
                if (e2 <= ln_dx)
                begin
                    ln_err = ln_err + ln_dx;
                    ln_y   = ln_dir[1] ? ln_y - UNIT : ln_y + UNIT;
                end
            end
        end
    endfunction

    function automatic void note_mismatch(input string field, input int want, input int got);
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
    endfunction

    // Input driver: presents queued words, waiting a drawn number of cycles after each one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_START;
            tx_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                trace_pixel(tx_word);
                words_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    tx_word = pending_words.pop_front();
                    s_tdata  <= IN_W'({tx_word.colour, tx_word.y1, tx_word.x1,
                                       tx_word.y0, tx_word.x0});
                    s_tuser  <= tx_word.op;
                    s_tvalid <= 1'b1;
                    tx_wait = tx_calm ? 0 : $urandom_range(0, 12);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Pixel monitor: checks each accepted pixel word, then stalls for a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel word arrived with none outstanding");
                    mismatches++;
                end
                else
                begin
                    pixel_t want;
                    want = expected_pixels.pop_front();
                    if (m_tdata[PX_LO +: PW] !== want.x)
                        note_mismatch("pixel_x", $signed(want.x), $signed(m_tdata[PX_LO +: PW]));
                    if (m_tdata[PY_LO +: PW] !== want.y)
                        note_mismatch("pixel_y", $signed(want.y), $signed(m_tdata[PY_LO +: PW]));
                    if (m_tdata[PC_LO +: KW] !== want.colour)
                        note_mismatch("pixel_color", want.colour, m_tdata[PC_LO +: KW]);
                    if (m_tuser !== want.draw)
                        note_mismatch("draw", want.draw, m_tuser);
                    if (m_tlast !== want.last)
                        note_mismatch("last", want.last, m_tlast);
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 12);
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic queue_word(input logic op, input int x0, y0, x1, y1,
                              input logic [23:0] colour);
        line_word_t w;
        w.op     = op;
        w.x0     = CW'(x0);
        w.y0     = CW'(y0);
        w.x1     = CW'(x1);
        w.y1     = CW'(y1);
        w.colour = colour;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Step words carry junk in the unused fields.
    task automatic queue_steps(input int n);
        for (int i = 0; i < n; i++)
            queue_word(OP_STEP, $urandom_range(0, X_MAX), $urandom_range(0, X_MAX),
                       $urandom_range(0, X_MAX), $urandom_range(0, X_MAX), 24'($urandom));
    endtask

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > X_MAX) ? X_MAX : v;
    endfunction

    // A start word and its steps; mostly just enough to finish, sometimes short or over-long.
    task automatic queue_random_line(input int reach, input bit leave_open);
        int x0, y0, x1, y1, ax, ay, span, full, n, pick, jitter;
        x0 = $urandom_range(0, X_MAX);
        y0 = $urandom_range(0, X_MAX);
        jitter = $urandom_range(0, 2 * reach);
        x1 = clamp_coord(x0 + jitter - reach);
        jitter = $urandom_range(0, 2 * reach);
        y1 = clamp_coord(y0 + jitter - reach);
        ax = (x1 > x0) ? x1 - x0 : x0 - x1;
        ay = (y1 > y0) ? y1 - y0 : y0 - y1;
        span = ((ax > ay) ? ax : ay) + 1;
        full = span * ((style_q == STYLE_THICK) ? 2 * (thick_q / 2) + 1 : 1);
        pick = $urandom_range(0, 9);
        if (leave_open)
            n = full / 2;
        else if (pick == 0)
            n = $urandom_range(0, full - 1);
        else if (pick == 1)
            n = full + $urandom_range(1, 3);
        else
            n = full;
        queue_word(OP_START, x0, y0, x1, y1, 24'($urandom));
        queue_steps(n);
        open_steps = (full > n) ? full - n : 0;
    endtask

    // Waits until every queued word is taken and every pixel has come, then lets the
    // two pipeline stages empty, since step words on an idle engine leave no trace.
    task automatic wait_for_drain();
        do
            @(posedge clk);
        while (words_taken != words_queued || expected_pixels.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Writes all three registers back to back; the spare upper data bits are randomised.
    task automatic write_registers(input logic [STYLE_BITS-1:0] style,
                                   input logic [THICK_BITS-1:0] thick,
                                   input logic [DASH_BITS-1:0] dash);
        logic [CFG_INDEX_BITS-1:0] idx[3];
        logic [CFG_DATA_BITS-1:0]  val[3];
        idx[0] = REG_LINE_STYLE;
        idx[1] = REG_THICKNESS;
        idx[2] = REG_DASH_LENGTH;
        val[0] = {6'($urandom), style};
        val[1] = {2'($urandom), thick};
        val[2] = dash;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                REG_LINE_STYLE:  style_q = val[i][STYLE_BITS-1:0];
                REG_THICKNESS:   thick_q = val[i][THICK_BITS-1:0];
                REG_DASH_LENGTH: dash_q  = val[i][DASH_BITS-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [STYLE_BITS-1:0] style;
        logic [THICK_BITS-1:0] thick;
        logic [DASH_BITS-1:0]  dash;
        int target;
        int reach;
        int guard;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings. A step on an idle engine gives nothing.
        queue_steps(1);
        // Single-point line, then a step once it is over.
        queue_word(OP_START, 0, 0, 0, 0, 24'h000000);
        queue_steps(2);
        // Lines at the far corner and edges in several directions of travel, the first in full colour.
        queue_word(OP_START, X_MAX, X_MAX, X_MAX - 3, X_MAX - 1, 24'hFFFFFF);
        queue_steps(4);
        // Start while busy: the first line is dropped two pixels in.
        queue_word(OP_START, X_MAX, 0, X_MAX - 2, 3, 24'h5A5A5A);
        queue_steps(2);
        queue_word(OP_START, 0, X_MAX, 3, X_MAX - 1, 24'hA5A5A5);
        queue_steps(4);
        queue_word(OP_START, 5, 5, 5, 7, 24'($urandom));
        queue_steps(3);
        // Style changed mid-line: the solid line picks up a second, offset pass.
        queue_word(OP_START, 100, 100, 102, 101, 24'($urandom));
        queue_steps(1);
        wait_for_drain();
        write_registers(STYLE_THICK, 6'd2, RESET_DASH_LENGTH);
        queue_steps(5);

        // Random phases, each under its own settings. The last line of a phase is left
        // open so that the next settings apply to a line already in progress.
        for (int ph = 0; ph < 12; ph++)
        begin
            dash  = DASH_BITS'($urandom_range(0, 12));
            thick = THICK_BITS'($urandom_range(0, 9));
            case (ph)
                0: begin style = STYLE_SOLID; thick = RESET_THICKNESS; dash = RESET_DASH_LENGTH; end
                1: begin style = STYLE_THICK;  thick = 6'd0;  end
                2: begin style = STYLE_THICK;  thick = 6'd63; end
                3: begin style = STYLE_DASHED; dash = 8'd0;   end
                4: begin style = STYLE_DASHED; dash = 8'd1;   end
                5: begin style = STYLE_DASHED; dash = 8'd255; end
                6: style = STYLE_SPARE;
                default:
                begin
                    style = STYLE_BITS'($urandom_range(0, 3));
                    if ($urandom_range(0, 4) == 0)
                        thick = THICK_BITS'($urandom_range(0, 63));
                end
            endcase
            wait_for_drain();
            write_registers(style, thick, dash);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            queue_steps(open_steps);
            open_steps = 0;
            target = words_queued + 20;
            while (words_queued < target)
            begin
                // Noise: a stray word with random content.
                if ($urandom_range(0, 9) == 0)
                    queue_word(1'($urandom_range(0, 1)), $urandom_range(0, X_MAX),
                               $urandom_range(0, X_MAX), $urandom_range(0, X_MAX),
                               $urandom_range(0, X_MAX), 24'($urandom));
                // Wide thick settings get very short lines to keep the pass count in bounds.
                reach = (thick_q > 9) ? 1 : (ph == 5) ? 300 :
                        (($urandom_range(0, 7) == 0) ? 40 : 8);
                queue_random_line(reach, 1'b0);
                // In every third phase the sender holds off after each line until every pixel is in.
                if (ph % 3 == 1 && words_queued >= target - 30 && words_queued < target)
                    wait_for_drain();
            end
            // A long open line ahead of the short dash setting lets the counter wrap.
            queue_random_line((ph == 3) ? 600 : (thick_q > 9) ? 1 : 8, 1'b1);
        end

        do
            @(posedge clk);
        while (words_taken != words_queued);
        guard = 0;
        while (expected_pixels.size() != 0 && guard < 500)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $error("%0d expected pixel words never arrived", expected_pixels.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
